/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules.
// Each macro expects i_clk and i_rst_n to exist in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

/* rtl/pcab_pkg.sv */
// ----------------------------------------------------------------------------
// Polygon convexity, area and bounding box: shared package
// Types, widths and helpers used by the front, the queue and the back.
// ----------------------------------------------------------------------------
package pcab_pkg;

    localparam int COORD_W    = 24;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int CROSS_P_W  = 2 * DIFF_W;
    localparam int EDGE_W     = PROD_W + 1;
    localparam int CROSS_W    = CROSS_P_W + 1;
    localparam int SUM_W      = 60;
    localparam int AREA_W     = 50;
    localparam int TOTAL_BITS = 10;
    localparam int TOTAL_MAX  = 1023;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 160;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;

    typedef enum logic [1:0] {
        FRONT_RUN,
        FRONT_CLOSE1,
        FRONT_CLOSE2
    } t_front_state;

    typedef struct packed {
        t_coord min_x;
        t_coord max_x;
        t_coord min_y;
        t_coord max_y;
    } t_box;

    typedef struct packed {
        logic                  fin;
        logic                  has_area;
        t_box                  box;
        logic [TOTAL_BITS-1:0] total;
        logic                  ovf;
    } t_meta;

    typedef struct packed {
        logic   edge_en;
        t_coord ex_a;
        t_coord ey_a;
        t_coord ex_b;
        t_coord ey_b;
        logic   turn_en;
        t_diff  d_bax;
        t_diff  d_cyb;
        t_diff  d_bay;
        t_diff  d_cxb;
        t_meta  meta;
    } t_op;

    typedef struct packed {
        logic                        edge_en;
        logic                        turn_en;
        t_meta                       meta;
        logic signed [PROD_W-1:0]    p0;
        logic signed [PROD_W-1:0]    p1;
        logic signed [CROSS_P_W-1:0] q0;
        logic signed [CROSS_P_W-1:0] q1;
    } t_prod;

    typedef struct packed {
        logic                      edge_en;
        logic                      turn_en;
        t_meta                     meta;
        logic signed [EDGE_W-1:0]  edge_term;
        logic signed [CROSS_W-1:0] turn_val;
    } t_term;

    typedef struct packed {
        t_box                  box;
        logic [AREA_W-1:0]     area;
        logic                  convex;
        logic [TOTAL_BITS-1:0] total;
        logic                  ovf;
    } t_result;

    function automatic t_diff coord_diff(input t_coord a, input t_coord b);
        return t_diff'(a) - t_diff'(b);
    endfunction

endpackage

/* rtl/pcab_front.sv */
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Polygon front end
// Accepts vertices, keeps the box, count and vertex history, and issues one
// operation per vertex plus two closing operations for a contour of three or more vertices.
// ----------------------------------------------------------------------------
module pcab_front #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [pcab_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tlast,
    output logic                            o_push,
    output pcab_pkg::t_op                   o_op,
    input  logic                            i_full
);
    import pcab_pkg::*;

    localparam int CW = $clog2(MAX_VERTICES);
    localparam int TW = (CW > TOTAL_BITS) ? CW : TOTAL_BITS;
    localparam int SH = COORD_W - COORD_BITS;
    localparam logic [CW-1:0] CAP = CW'(MAX_VERTICES - 1);

    typedef struct packed {
        t_coord first_x;
        t_coord first_y;
        t_coord second_x;
        t_coord second_y;
        t_coord older_x;
        t_coord older_y;
        t_coord recent_x;
        t_coord recent_y;
    } t_hist;

    t_front_state  r_state, n_state;
    t_hist         r_hist, n_hist;
    t_box          r_box, n_box;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;

    t_coord raw_x, raw_y, vx, vy;
    logic   accept;

    assign raw_x = i_s_tdata[COORD_W-1:0];
    assign raw_y = i_s_tdata[2*COORD_W-1:COORD_W];
    assign vx    = (raw_x <<< SH) >>> SH;
    assign vy    = (raw_y <<< SH) >>> SH;

    assign o_s_tready = (r_state == FRONT_RUN) && !i_full;
    assign accept     = i_s_tvalid && o_s_tready;

    function automatic t_meta make_meta(input logic fin, input logic has_area,
                                        input t_box box, input logic [CW-1:0] cnt,
                                        input logic ovf);
        t_meta           m;
        logic [TW-1:0]   wide;
        wide       = TW'(cnt);
        m.fin      = fin;
        m.has_area = has_area;
        m.box      = box;
        if (wide > TW'(TOTAL_MAX)) begin
            m.total = TOTAL_BITS'(TOTAL_MAX);
            m.ovf   = 1'b1;
        end else begin
            m.total = TOTAL_BITS'(wide);
            m.ovf   = ovf;
        end
        return m;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FRONT_RUN;
            r_hist  <= '0;
            r_box   <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hist  <= n_hist;
            r_box   <= n_box;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    always_comb begin
        n_state = r_state;
        n_hist  = r_hist;
        n_box   = r_box;
        n_count = r_count;
        n_ovf   = r_ovf;
        o_push  = 1'b0;
        o_op    = '0;
        unique case (r_state)
            FRONT_RUN: begin
                if (accept) begin
                    o_push        = 1'b1;
                    o_op.edge_en  = (r_count != '0);
                    o_op.ex_a     = r_hist.recent_x;
                    o_op.ey_a     = r_hist.recent_y;
                    o_op.ex_b     = vx;
                    o_op.ey_b     = vy;
                    o_op.turn_en  = (r_count != '0) && (r_count != CW'(1));
                    o_op.d_bax    = coord_diff(r_hist.recent_x, r_hist.older_x);
                    o_op.d_cyb    = coord_diff(vy, r_hist.recent_y);
                    o_op.d_bay    = coord_diff(r_hist.recent_y, r_hist.older_y);
                    o_op.d_cxb    = coord_diff(vx, r_hist.recent_x);
                    if (r_count == '0) begin
                        n_hist.first_x = vx;
                        n_hist.first_y = vy;
                        n_box.min_x    = vx;
                        n_box.max_x    = vx;
                        n_box.min_y    = vy;
                        n_box.max_y    = vy;
                    end else begin
                        if (vx < r_box.min_x) n_box.min_x = vx;
                        if (vx > r_box.max_x) n_box.max_x = vx;
                        if (vy < r_box.min_y) n_box.min_y = vy;
                        if (vy > r_box.max_y) n_box.max_y = vy;
                        if (r_count == CW'(1)) begin
                            n_hist.second_x = vx;
                            n_hist.second_y = vy;
                        end
                    end
                    n_hist.older_x  = r_hist.recent_x;
                    n_hist.older_y  = r_hist.recent_y;
                    n_hist.recent_x = vx;
                    n_hist.recent_y = vy;
                    if (r_count == CAP) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                    if (i_s_tlast) begin
                        if (n_count >= CW'(3)) begin
                            n_state = FRONT_CLOSE1;
                        end else begin
                            o_op.meta = make_meta(1'b1, 1'b0, n_box, n_count, n_ovf);
                            n_hist    = '0;
                            n_box     = '0;
                            n_count   = '0;
                            n_ovf     = 1'b0;
                        end
                    end
                end
            end
            FRONT_CLOSE1: begin
                if (!i_full) begin
                    o_push       = 1'b1;
                    o_op.edge_en = 1'b1;
                    o_op.ex_a    = r_hist.recent_x;
                    o_op.ey_a    = r_hist.recent_y;
                    o_op.ex_b    = r_hist.first_x;
                    o_op.ey_b    = r_hist.first_y;
                    o_op.turn_en = 1'b1;
                    o_op.d_bax   = coord_diff(r_hist.recent_x, r_hist.older_x);
                    o_op.d_cyb   = coord_diff(r_hist.first_y, r_hist.recent_y);
                    o_op.d_bay   = coord_diff(r_hist.recent_y, r_hist.older_y);
                    o_op.d_cxb   = coord_diff(r_hist.first_x, r_hist.recent_x);
                    n_state      = FRONT_CLOSE2;
                end
            end
            FRONT_CLOSE2: begin
                if (!i_full) begin
                    o_push       = 1'b1;
                    o_op.turn_en = 1'b1;
                    o_op.d_bax   = coord_diff(r_hist.first_x, r_hist.recent_x);
                    o_op.d_cyb   = coord_diff(r_hist.second_y, r_hist.first_y);
                    o_op.d_bay   = coord_diff(r_hist.first_y, r_hist.recent_y);
                    o_op.d_cxb   = coord_diff(r_hist.second_x, r_hist.first_x);
                    o_op.meta    = make_meta(1'b1, 1'b1, r_box, r_count, r_ovf);
                    n_hist       = '0;
                    n_box        = '0;
                    n_count      = '0;
                    n_ovf        = 1'b0;
                    n_state      = FRONT_RUN;
                end
            end
            default: begin
                n_state = FRONT_RUN;
            end
        endcase
    end

    `ASSERT_CLK(a_close_blocks_input, (r_state != FRONT_RUN) |-> !o_s_tready, "Vertex taken while closing a contour.")

endmodule

/* rtl/pcab_queue.sv */
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Operation queue
// Two-entry first-in first-out store between the front and the back.
// ----------------------------------------------------------------------------
module pcab_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pcab_pkg::t_op i_data,
    output logic          o_full,
    output logic          o_valid,
    output pcab_pkg::t_op o_data,
    input  logic          i_pop
);
    import pcab_pkg::*;

    t_op                 r_entry [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            if (do_push && !do_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_entry[r_wr_ptr] <= i_data;
    end

    `ASSERT_NEVER(a_push_when_full, i_push && o_full, "Operation pushed into a full queue.")

endmodule

/* rtl/pcab_back.sv */
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Polygon back end
// Multiplies, accumulates the shoelace sum and turn signs, and forms the
// result of each contour in an output register.
// ----------------------------------------------------------------------------
module pcab_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  pcab_pkg::t_op     i_q_data,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output pcab_pkg::t_result o_result
);
    import pcab_pkg::*;

    t_prod             r_s1, n_s1;
    t_term             r_s2, n_s2;
    logic              r_s1_valid, r_s2_valid;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic              r_pos, r_neg, n_pos, n_neg;
    logic [SUM_W-1:0]  r_fin_sum;
    logic              r_fin_pos, r_fin_neg, r_fin_valid;
    t_meta             r_fin_meta;
    t_result           r_out, n_out;
    logic              r_out_valid;
    logic              out_free, fin_move, fin_free, adv, fin_load;
    logic [SUM_W-1:0]  mag;

    assign out_free = !r_out_valid || i_ready;
    assign fin_move = r_fin_valid && out_free;
    assign fin_free = !r_fin_valid || out_free;
    assign adv      = !(r_s2_valid && r_s2.meta.fin) || fin_free;
    assign fin_load = adv && r_s2_valid && r_s2.meta.fin;
    assign o_q_pop  = adv && i_q_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_s1.edge_en = i_q_data.edge_en;
        n_s1.turn_en = i_q_data.turn_en;
        n_s1.meta    = i_q_data.meta;
        n_s1.p0      = i_q_data.ex_a * i_q_data.ey_b;
        n_s1.p1      = i_q_data.ex_b * i_q_data.ey_a;
        n_s1.q0      = i_q_data.d_bax * i_q_data.d_cyb;
        n_s1.q1      = i_q_data.d_bay * i_q_data.d_cxb;

        n_s2.edge_en   = r_s1.edge_en;
        n_s2.turn_en   = r_s1.turn_en;
        n_s2.meta      = r_s1.meta;
        n_s2.edge_term = EDGE_W'($signed(r_s1.p0)) - EDGE_W'($signed(r_s1.p1));
        n_s2.turn_val  = CROSS_W'($signed(r_s1.q0)) - CROSS_W'($signed(r_s1.q1));
    end

    always_comb begin
        n_sum = r_sum;
        n_pos = r_pos;
        n_neg = r_neg;
        if (r_s2.edge_en) begin
            n_sum = r_sum + SUM_W'($signed(r_s2.edge_term));
        end
        if (r_s2.turn_en) begin
            if (r_s2.turn_val[CROSS_W-1]) begin
                n_neg = 1'b1;
            end else if (r_s2.turn_val != '0) begin
                n_pos = 1'b1;
            end
        end
    end

    always_comb begin
        mag = r_fin_sum[SUM_W-1] ? (~r_fin_sum + SUM_W'(1)) : r_fin_sum;
        n_out.box    = r_fin_meta.box;
        n_out.total  = r_fin_meta.total;
        n_out.ovf    = r_fin_meta.ovf;
        n_out.convex = r_fin_meta.has_area && (r_fin_pos != r_fin_neg);
        if (!r_fin_meta.has_area) begin
            n_out.area = '0;
        end else if (mag[SUM_W-1:AREA_W] != '0) begin
            n_out.area = '1;
        end else begin
            n_out.area = mag[AREA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_sum       <= '0;
            r_pos       <= 1'b0;
            r_neg       <= 1'b0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_s1_valid <= i_q_valid;
                r_s2_valid <= r_s1_valid;
                if (r_s2_valid) begin
                    if (r_s2.meta.fin) begin
                        r_sum <= '0;
                        r_pos <= 1'b0;
                        r_neg <= 1'b0;
                    end else begin
                        r_sum <= n_sum;
                        r_pos <= n_pos;
                        r_neg <= n_neg;
                    end
                end
            end
            if (fin_load) begin
                r_fin_valid <= 1'b1;
            end else if (fin_move) begin
                r_fin_valid <= 1'b0;
            end
            if (fin_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
        if (fin_load) begin
            r_fin_sum  <= n_sum;
            r_fin_pos  <= n_pos;
            r_fin_neg  <= n_neg;
            r_fin_meta <= r_s2.meta;
        end
        if (fin_move) begin
            r_out <= n_out;
        end
    end

    `ASSERT_CLK(a_sum_cleared, fin_load |=> (r_sum == '0), "Shoelace sum not cleared after a contour.")
    `ASSERT_NEVER(a_fin_overwrite, fin_load && r_fin_valid && !out_free, "Pending contour result overwritten.")
    `ASSERT_CLK(a_convex_count, (o_valid && o_result.convex) |-> (o_result.total >= TOTAL_BITS'(3)), "Convex result with fewer than three vertices.")

endmodule

/* rtl/polygon_convexity_area_bbox.sv */
// ----------------------------------------------------------------------------
// Polygon convexity, shoelace area and bounding box
// Streams the vertices of closed contours and gives one result per contour.
// ----------------------------------------------------------------------------
// The slave stream carries one vertex per word: x and y in tdata, and tlast on
// the final vertex of a contour. The master stream carries one word per
// contour: the bounding box, twice the absolute area, the convex flag, the
// saturated vertex count and the count overflow flag.
// A vertex is taken every cycle while the queue has room. A closing vertex of
// three or more makes the front issue two more operations, and the slave side
// is held off while it issues them. The result of a contour passes through the
// queue, the multiplier stage, the subtractor stage, the holding register and
// the output register, behind the two closing operations when there are three
// or more vertices. A two-entry queue parts the front from the multiplier pipeline.
// After reset all running sums, the box and the count are zero and both
// streams are empty. When the receiver stalls, one result waits in the output
// register and a second in a holding register; the pipeline and then the
// queue fill behind them before the slave side is held off.
// ----------------------------------------------------------------------------
module polygon_convexity_area_bbox #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // vx [23:0], vy [47:24]
    input  logic [pcab_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic                             i_s_tlast,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // box_min_x [23:0], box_max_x [47:24], box_min_y [71:48],
    // box_max_y [95:72], area_twice [145:96], is_convex [146],
    // vertex_total [156:147], count_overflow [157], zero [159:158]
    output logic [pcab_pkg::OUT_DATA_W-1:0]  o_m_tdata
);
    import pcab_pkg::*;

    logic    push, full, q_valid, q_pop;
    t_op     push_op, q_data;
    t_result result;

    pcab_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_push     (push),
        .o_op       (push_op),
        .i_full     (full)
    );

    pcab_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_op),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    pcab_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_result  (result)
    );

    assign o_m_tdata = {2'b00, result.ovf, result.total, result.convex, result.area,
                        result.box.max_y, result.box.min_y,
                        result.box.max_x, result.box.min_x};

endmodule
